@@ design/fuzzy_load_transfer_decision_macros.svh @@
// Assertion helpers shared by the RTL of the fuzzy load-transfer block.
`ifndef FUZZY_LOAD_TRANSFER_DECISION_MACROS_SVH
`define FUZZY_LOAD_TRANSFER_DECISION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FLTD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fltd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FLTD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fltd assertion failed");

`endif

@@ design/fltd_pkg.sv @@
`default_nettype none
package fltd_pkg;

   localparam int CENTROID_SAMPLES_DEF   = 100;
   localparam int LOAD_FRACTION_BITS_DEF = 8;

   localparam int LOAD_W   = 15;
   localparam int DEG_W    = 16;
   localparam int PROB_W   = 16;
   localparam int AMOUNT_W = 14;
   localparam int TERMS    = 5;

   localparam logic [DEG_W-1:0]  DEG_ONE         = 16'h8000;
   localparam logic [PROB_W-1:0] THRESHOLD_RESET = 16'd16384;

   // Reciprocals for exact truncating division of a ramp distance by its length.
   localparam int RECIP_SHIFT = 25;
   localparam int RV_W        = 20;
   localparam int RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5);
   localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'(((1 << RECIP_SHIFT) + 9) / 10);
   localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(((1 << RECIP_SHIFT) + 14) / 15);
   localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'(((1 << RECIP_SHIFT) + 19) / 20);

   typedef enum logic [1:0] {
      STATUS_TRANSFER = 2'd0,
      STATUS_NO_MOVE  = 2'd1,
      STATUS_ESCALATE = 2'd2
   } status_type;

   typedef logic [TERMS-1:0][DEG_W-1:0] deg_vec_type;

   // [receiver level][sender level] -> output term
   localparam logic [2:0] RULE_OUT [TERMS][TERMS] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4},
      '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3},
      '{3'd0, 3'd0, 3'd0, 3'd1, 3'd2},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
   };

   // Degree from a ramp distance already scaled to Q1.15 times the ramp length.
   function automatic logic [DEG_W-1:0] ramp_div(input logic [RV_W-1:0] v,
                                                 input logic [RECIP_W-1:0] m);
      logic [RV_W+RECIP_W-1:0] prod;
      prod = (RV_W+RECIP_W)'(v) * (RV_W+RECIP_W)'(m);
      return DEG_W'(prod >> RECIP_SHIFT);
   endfunction

   // Aggregated output membership at one sample: max over terms of min(mu, act).
   function automatic logic [DEG_W-1:0] sample_y(input deg_vec_type act,
                                                 input deg_vec_type mu);
      logic [DEG_W-1:0] y;
      logic [DEG_W-1:0] m;
      y = '0;
      for (int i = 0; i < TERMS; i++) begin
         m = (mu[i] > act[i]) ? act[i] : mu[i];
         if (m > y) y = m;
      end
      return y;
   endfunction

endpackage
`default_nettype wire

@@ design/fuzzy_load_transfer_decision.sv @@
`default_nettype none
// Fuzzy load-transfer decision, fully pipelined.
// A transaction is accepted at a clock edge with start high; busy is always low,
// so a new load pair can be issued every cycle. Both loads are clamped to 100
// percent, fuzzified over five terms, run through the 5x5 min/max rule table
// and defuzzified by a sampled centroid, followed by a restoring divide.
// Each result is shown for one cycle with rsp_valid high, in issue order.
// The centroid pipeline adds four samples per stage and the divider retires
// one quotient bit per stage. Throughput is one transaction per cycle.
// The receiver cannot stall: results are never held back or dropped.
// The threshold register lies at byte address 0 of the APB-style port; it is
// to be written only while no transaction is in flight, which the block
// itself does not enforce. Reset empties the pipeline and restores the
// threshold to one half.
module fuzzy_load_transfer_decision #(
   parameter int CENTROID_SAMPLES   = fltd_pkg::CENTROID_SAMPLES_DEF,
   parameter int LOAD_FRACTION_BITS = fltd_pkg::LOAD_FRACTION_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [fltd_pkg::LOAD_W-1:0]         req_sender_load,
   input  wire logic [fltd_pkg::LOAD_W-1:0]         req_receiver_load,
   output logic                                     rsp_valid,
   output logic [fltd_pkg::PROB_W-1:0]              rsp_probability,
   output logic [fltd_pkg::AMOUNT_W-1:0]            rsp_transfer_amount,
   output fltd_pkg::status_type                     rsp_status,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [2:0]                          paddr,
   input  wire logic [31:0]                         pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);
   import fltd_pkg::*;

   localparam int F    = LOAD_FRACTION_BITS;
   localparam int CW   = (8 + F > 16) ? 8 + F : 16;
   localparam int SH   = 15 - F;
   localparam int N    = CENTROID_SAMPLES;
   localparam int CH   = 4;
   localparam int NSTG = (N + CH - 1) / CH;
   localparam int LGN  = $clog2(N);
   localparam int SY_W  = 16 + LGN;
   localparam int SYX_W = 16 + 2 * LGN;
   localparam int W     = 34 + 2 * LGN;
   localparam int DSTEPS = PROB_W;
   localparam longint TwoN = 2 * N;

   localparam logic [CW-1:0] P10  = CW'(10 * (1 << F));
   localparam logic [CW-1:0] P15  = CW'(15 * (1 << F));
   localparam logic [CW-1:0] P25  = CW'(25 * (1 << F));
   localparam logic [CW-1:0] P30  = CW'(30 * (1 << F));
   localparam logic [CW-1:0] P40  = CW'(40 * (1 << F));
   localparam logic [CW-1:0] P50  = CW'(50 * (1 << F));
   localparam logic [CW-1:0] P60  = CW'(60 * (1 << F));
   localparam logic [CW-1:0] P70  = CW'(70 * (1 << F));
   localparam logic [CW-1:0] P75  = CW'(75 * (1 << F));
   localparam logic [CW-1:0] P80  = CW'(80 * (1 << F));
   localparam logic [CW-1:0] P90  = CW'(90 * (1 << F));
   localparam logic [CW-1:0] P100 = CW'(100 * (1 << F));

   function automatic logic [RV_W-1:0] scl(input logic [CW-1:0] d);
      return RV_W'(d) << SH;
   endfunction

   function automatic deg_vec_type fuzzify(input logic [CW-1:0] x);
      deg_vec_type d;
      d = '0;
      if (x <= P10) d[0] = DEG_ONE;
      else if (x < P15) d[0] = ramp_div(scl(P15 - x), RECIP_5);
      if (x >= P10 && x < P25) d[1] = ramp_div(scl(x - P10), RECIP_15);
      else if (x == P25) d[1] = DEG_ONE;
      else if (x > P25 && x < P40) d[1] = ramp_div(scl(P40 - x), RECIP_15);
      if (x >= P30 && x < P50) d[2] = ramp_div(scl(x - P30), RECIP_20);
      else if (x == P50) d[2] = DEG_ONE;
      else if (x > P50 && x < P70) d[2] = ramp_div(scl(P70 - x), RECIP_20);
      if (x >= P60 && x < P75) d[3] = ramp_div(scl(x - P60), RECIP_15);
      else if (x == P75) d[3] = DEG_ONE;
      else if (x > P75 && x < P90) d[3] = ramp_div(scl(P90 - x), RECIP_15);
      if (x >= P80 && x < P90) d[4] = ramp_div(scl(x - P80), RECIP_10);
      else if (x >= P90) d[4] = DEG_ONE;
      return d;
   endfunction

   // Configuration register.
   logic [PROB_W-1:0] thr_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && !paddr[2];
   assign prdata    = paddr[2] ? 32'd0 : {16'd0, thr_ff};
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_write) begin
         thr_ff <= pwdata[PROB_W-1:0];
      end
   end

   // Stage 1: clamp.
   logic              s1_valid_ff;
   logic [LOAD_W-1:0] s1_s_ff, s1_r_ff;
   logic [LOAD_W-1:0] s1_s_in, s1_r_in;

   always_comb begin
      s1_s_in = (CW'(req_sender_load) > P100) ? LOAD_W'(P100) : req_sender_load;
      s1_r_in = (CW'(req_receiver_load) > P100) ? LOAD_W'(P100) : req_receiver_load;
   end

   // Stage 2: fuzzify both loads.
   logic              s2_valid_ff;
   deg_vec_type       s2_ds_ff, s2_dr_ff;
   logic [LOAD_W-1:0] s2_diff_ff;
   logic              s2_dpos_ff;

   // Stage 3: per receiver row, strongest firing of each output term.
   logic              s3_valid_ff;
   deg_vec_type       s3_part_ff [TERMS];
   deg_vec_type       s3_part_in [TERMS];
   logic [LOAD_W-1:0] s3_diff_ff;
   logic              s3_dpos_ff;

   always_comb begin
      logic [DEG_W-1:0] w;
      for (int i = 0; i < TERMS; i++) begin
         s3_part_in[i] = '0;
         for (int j = 0; j < TERMS; j++) begin
            w = (s2_ds_ff[j] < s2_dr_ff[i]) ? s2_ds_ff[j] : s2_dr_ff[i];
            if (w > s3_part_in[i][RULE_OUT[i][j]]) s3_part_in[i][RULE_OUT[i][j]] = w;
         end
      end
   end

   // Stage 4: aggregate activation over rows.
   logic              s4_valid_ff;
   deg_vec_type       s4_act_ff, s4_act_in;
   logic [LOAD_W-1:0] s4_diff_ff;
   logic              s4_dpos_ff;

   always_comb begin
      s4_act_in = '0;
      for (int t = 0; t < TERMS; t++) begin
         for (int i = 0; i < TERMS; i++) begin
            if (s3_part_ff[i][t] > s4_act_in[t]) s4_act_in[t] = s3_part_ff[i][t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_s_ff    <= s1_s_in;
      s1_r_ff    <= s1_r_in;
      s2_ds_ff   <= fuzzify(CW'(s1_s_ff));
      s2_dr_ff   <= fuzzify(CW'(s1_r_ff));
      s2_diff_ff <= s1_s_ff - s1_r_ff;
      s2_dpos_ff <= s1_s_ff > s1_r_ff;
      s3_part_ff <= s3_part_in;
      s3_diff_ff <= s2_diff_ff;
      s3_dpos_ff <= s2_dpos_ff;
      s4_act_ff  <= s4_act_in;
      s4_diff_ff <= s3_diff_ff;
      s4_dpos_ff <= s3_dpos_ff;
   end

   // Centroid accumulation, CH samples per stage.
   logic [NSTG-1:0]    c_valid_ff;
   deg_vec_type        c_act_ff  [NSTG];
   logic [SY_W-1:0]    c_sy_ff   [NSTG];
   logic [SYX_W-1:0]   c_syx_ff  [NSTG];
   logic [LOAD_W-1:0]  c_diff_ff [NSTG];
   logic [NSTG-1:0]    c_dpos_ff;
   deg_vec_type        ci_act    [NSTG];
   logic [SY_W-1:0]    ci_sy     [NSTG];
   logic [SYX_W-1:0]   ci_syx    [NSTG];
   logic [LOAD_W-1:0]  ci_diff   [NSTG];
   logic [NSTG-1:0]    ci_dpos;
   logic [NSTG-1:0]    ci_valid;
   logic [SY_W-1:0]    co_sy     [NSTG];
   logic [SYX_W-1:0]   co_syx    [NSTG];
   logic [DEG_W-1:0]   ymat      [NSTG][CH];

   for (genvar g = 0; g < NSTG; g++) begin : g_cstage
      if (g == 0) begin : g_first
         assign ci_act[g]   = s4_act_ff;
         assign ci_sy[g]    = '0;
         assign ci_syx[g]   = '0;
         assign ci_diff[g]  = s4_diff_ff;
         assign ci_dpos[g]  = s4_dpos_ff;
         assign ci_valid[g] = s4_valid_ff;
      end else begin : g_rest
         assign ci_act[g]   = c_act_ff[g-1];
         assign ci_sy[g]    = c_sy_ff[g-1];
         assign ci_syx[g]   = c_syx_ff[g-1];
         assign ci_diff[g]  = c_diff_ff[g-1];
         assign ci_dpos[g]  = c_dpos_ff[g-1];
         assign ci_valid[g] = c_valid_ff[g-1];
      end

      for (genvar c = 0; c < CH; c++) begin : g_smp
         localparam longint K  = g * CH + c;
         localparam longint X  = (2 * K + 1) * 20;
         localparam longint M0 = (X <= 3 * TwoN) ? 32768 :
                                 (X < 4 * TwoN) ? ((4 * TwoN - X) * 32768) / TwoN : 0;
         localparam longint M1 = (X < 2 * TwoN) ? 0 :
                                 (X < 5 * TwoN) ? ((X - 2 * TwoN) * 32768) / (3 * TwoN) :
                                 (X == 5 * TwoN) ? 32768 :
                                 (X < 8 * TwoN) ? ((8 * TwoN - X) * 32768) / (3 * TwoN) : 0;
         localparam longint M2 = (X < 6 * TwoN) ? 0 :
                                 (X < 10 * TwoN) ? ((X - 6 * TwoN) * 32768) / (4 * TwoN) :
                                 (X == 10 * TwoN) ? 32768 :
                                 (X < 14 * TwoN) ? ((14 * TwoN - X) * 32768) / (4 * TwoN) : 0;
         localparam longint M3 = (X < 12 * TwoN) ? 0 :
                                 (X < 15 * TwoN) ? ((X - 12 * TwoN) * 32768) / (3 * TwoN) :
                                 (X == 15 * TwoN) ? 32768 :
                                 (X < 18 * TwoN) ? ((18 * TwoN - X) * 32768) / (3 * TwoN) : 0;
         localparam longint M4 = (X < 16 * TwoN) ? 0 :
                                 (X < 18 * TwoN) ? ((X - 16 * TwoN) * 32768) / (2 * TwoN) :
                                 32768;
         localparam deg_vec_type MU = {DEG_W'(M4), DEG_W'(M3), DEG_W'(M2),
                                       DEG_W'(M1), DEG_W'(M0)};
         if (K < N) begin : g_live
            assign ymat[g][c] = sample_y(ci_act[g], MU);
         end else begin : g_pad
            assign ymat[g][c] = '0;
         end
      end

      always_comb begin
         co_sy[g]  = ci_sy[g];
         co_syx[g] = ci_syx[g];
         for (int c = 0; c < CH; c++) begin
            co_sy[g]  = co_sy[g] + SY_W'(ymat[g][c]);
            co_syx[g] = co_syx[g] + SYX_W'(ymat[g][c]) * SYX_W'(2 * (g * CH + c) + 1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            c_valid_ff[g] <= 1'b0;
         end else begin
            c_valid_ff[g] <= ci_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         c_act_ff[g]  <= ci_act[g];
         c_sy_ff[g]   <= co_sy[g];
         c_syx_ff[g]  <= co_syx[g];
         c_diff_ff[g] <= ci_diff[g];
         c_dpos_ff[g] <= ci_dpos[g];
      end
   end

   // Divider operands: numerator carries the rounding half of the denominator.
   logic              pr_valid_ff;
   logic [W-1:0]      pr_num_ff, pr_den_ff;
   logic [W-1:0]      pr_den_in;
   logic              pr_nz_ff;
   logic [LOAD_W-1:0] pr_diff_ff;
   logic              pr_dpos_ff;

   assign pr_den_in = W'(c_sy_ff[NSTG-1]) * W'(TwoN);

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else begin
         pr_valid_ff <= c_valid_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      pr_den_ff  <= pr_den_in;
      pr_num_ff  <= (W'(c_syx_ff[NSTG-1]) << 15) + (pr_den_in >> 1);
      pr_nz_ff   <= c_sy_ff[NSTG-1] != '0;
      pr_diff_ff <= c_diff_ff[NSTG-1];
      pr_dpos_ff <= c_dpos_ff[NSTG-1];
   end

   // Restoring divider, one quotient bit per stage, most significant first.
   logic [DSTEPS-1:0] dv_valid_ff;
   logic [W-1:0]      dv_rem_ff  [DSTEPS];
   logic [W-1:0]      dv_den_ff  [DSTEPS];
   logic [PROB_W-1:0] dv_q_ff    [DSTEPS];
   logic [DSTEPS-1:0] dv_nz_ff;
   logic [LOAD_W-1:0] dv_diff_ff [DSTEPS];
   logic [DSTEPS-1:0] dv_dpos_ff;
   logic [DSTEPS-1:0] di_valid;
   logic [W-1:0]      di_rem     [DSTEPS];
   logic [W-1:0]      di_den     [DSTEPS];
   logic [PROB_W-1:0] di_q       [DSTEPS];
   logic [DSTEPS-1:0] di_nz;
   logic [LOAD_W-1:0] di_diff    [DSTEPS];
   logic [DSTEPS-1:0] di_dpos;

   for (genvar d = 0; d < DSTEPS; d++) begin : g_div
      localparam int B = DSTEPS - 1 - d;
      logic [W-1:0] shifted;

      if (d == 0) begin : g_first
         assign di_valid[d] = pr_valid_ff;
         assign di_rem[d]   = pr_num_ff;
         assign di_den[d]   = pr_den_ff;
         assign di_q[d]     = '0;
         assign di_nz[d]    = pr_nz_ff;
         assign di_diff[d]  = pr_diff_ff;
         assign di_dpos[d]  = pr_dpos_ff;
      end else begin : g_rest
         assign di_valid[d] = dv_valid_ff[d-1];
         assign di_rem[d]   = dv_rem_ff[d-1];
         assign di_den[d]   = dv_den_ff[d-1];
         assign di_q[d]     = dv_q_ff[d-1];
         assign di_nz[d]    = dv_nz_ff[d-1];
         assign di_diff[d]  = dv_diff_ff[d-1];
         assign di_dpos[d]  = dv_dpos_ff[d-1];
      end

      assign shifted = di_den[d] << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[d] <= 1'b0;
         end else begin
            dv_valid_ff[d] <= di_valid[d];
         end
      end

      always_ff @(posedge clock) begin
         if (di_rem[d] >= shifted) begin
            dv_rem_ff[d] <= di_rem[d] - shifted;
            dv_q_ff[d]   <= di_q[d] | (PROB_W'(1) << B);
         end else begin
            dv_rem_ff[d] <= di_rem[d];
            dv_q_ff[d]   <= di_q[d];
         end
         dv_den_ff[d]  <= di_den[d];
         dv_nz_ff[d]   <= di_nz[d];
         dv_diff_ff[d] <= di_diff[d];
         dv_dpos_ff[d] <= di_dpos[d];
      end
   end

   // Threshold test and amount product.
   logic                     f1_valid_ff;
   logic [PROB_W-1:0]        f1_p_ff, f1_p_in;
   logic                     f1_gt_ff;
   logic                     f1_dpos_ff;
   logic [PROB_W+LOAD_W-1:0] f1_prod_ff;

   assign f1_p_in = dv_nz_ff[DSTEPS-1] ? dv_q_ff[DSTEPS-1] : '0;

   // Output register.
   logic                  rsp_valid_ff;
   logic [PROB_W-1:0]     rsp_prob_ff;
   logic [AMOUNT_W-1:0]   rsp_amount_ff, rsp_amount_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [LOAD_W-1:0]     amt_full;

   always_comb begin
      amt_full      = LOAD_W'(f1_prod_ff >> 16);
      rsp_amount_in = '0;
      rsp_status_in = STATUS_ESCALATE;
      if (f1_gt_ff) begin
         rsp_status_in = STATUS_NO_MOVE;
         if (f1_dpos_ff && amt_full != '0) begin
            rsp_status_in = STATUS_TRANSFER;
            rsp_amount_in = (amt_full > LOAD_W'({AMOUNT_W{1'b1}})) ?
                            {AMOUNT_W{1'b1}} : AMOUNT_W'(amt_full);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff  <= dv_valid_ff[DSTEPS-1];
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_p_ff       <= f1_p_in;
      f1_gt_ff      <= f1_p_in > thr_ff;
      f1_dpos_ff    <= dv_dpos_ff[DSTEPS-1];
      f1_prod_ff    <= (PROB_W+LOAD_W)'(f1_p_in) * (PROB_W+LOAD_W)'(dv_diff_ff[DSTEPS-1]);
      rsp_prob_ff   <= f1_p_ff;
      rsp_amount_ff <= rsp_amount_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_probability     = rsp_prob_ff;
   assign rsp_transfer_amount = rsp_amount_ff;
   assign rsp_status          = rsp_status_ff;

`include "fuzzy_load_transfer_decision_macros.svh"

   `FLTD_ASSERT_NEXT(a_accept_enters, clock, reset, start, s1_valid_ff)
   `FLTD_ASSERT_IMPLY(a_some_term_fires, clock, reset, s4_valid_ff, s4_act_ff != '0)
   `FLTD_ASSERT_IMPLY(a_prob_range, clock, reset, rsp_valid_ff, rsp_prob_ff <= DEG_ONE)
   `FLTD_ASSERT_IMPLY(a_amount_only_on_transfer, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_TRANSFER), rsp_amount_ff == '0)
   `FLTD_ASSERT_IMPLY(a_transfer_above_thr, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_TRANSFER), rsp_prob_ff > thr_ff)

endmodule
`default_nettype wire

@@ bench/fuzzy_load_transfer_decision_tb.sv @@
`timescale 1ns / 1ps
module fuzzy_load_transfer_decision_tb;
   import fltd_pkg::*;

   localparam int LOAD_FULL     = 100 << 8;
   localparam int SAMPLES       = 100;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 300000;
   localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

   // Breakpoints in percent for the load terms, in twentieths for the output terms.
   localparam int LOAD_TERM [TERMS][4] = '{
      '{0, 0, 10, 15}, '{10, 25, 25, 40}, '{30, 50, 50, 70},
      '{60, 75, 75, 90}, '{80, 90, 100, 100}};
   localparam int PROB_TERM [TERMS][4] = '{
      '{0, 0, 3, 4}, '{2, 5, 5, 8}, '{6, 10, 10, 14},
      '{12, 15, 15, 18}, '{16, 18, 20, 20}};
   localparam int DECISION_RULE [TERMS][TERMS] = '{
      '{0, 1, 2, 3, 4}, '{0, 0, 1, 2, 3}, '{0, 0, 0, 1, 2},
      '{0, 0, 0, 0, 1}, '{0, 0, 0, 0, 0}};

   typedef struct packed {
      logic [PROB_W-1:0]   probability;
      logic [AMOUNT_W-1:0] amount;
      status_type          status;
   } decision_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [LOAD_W-1:0]   req_sender_load = '0;
   logic [LOAD_W-1:0]   req_receiver_load = '0;
   logic                rsp_valid;
   logic [PROB_W-1:0]   rsp_probability;
   logic [AMOUNT_W-1:0] rsp_transfer_amount;
   status_type          rsp_status;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [2:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   decision_type        pending_decisions[$];
   logic [PROB_W-1:0]   threshold_copy = THRESHOLD_RESET;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   fuzzy_load_transfer_decision u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sender_load(req_sender_load), .req_receiver_load(req_receiver_load),
      .rsp_valid(rsp_valid), .rsp_probability(rsp_probability),
      .rsp_transfer_amount(rsp_transfer_amount), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready));

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic longint unsigned ramp_degree(input longint unsigned x,
                                                   input int bp [4],
                                                   input longint unsigned mul);
      longint unsigned a, b, c, d;
      a = bp[0] * mul;
      b = bp[1] * mul;
      c = bp[2] * mul;
      d = bp[3] * mul;
      if (x < a || x > d) return 0;
      if (x < b) return ((x - a) * 32768) / (b - a);
      if (x <= c) return 32768;
      if (x < d) return ((d - x) * 32768) / (d - c);
      return 0;
   endfunction

   function automatic decision_type predict_decision(input logic [LOAD_W-1:0] sender,
                                                     input logic [LOAD_W-1:0] receiver);
      longint unsigned s, r, w, y, m, sum_y, sum_yx, den, p, amount;
      longint unsigned deg_s [TERMS];
      longint unsigned deg_r [TERMS];
      longint unsigned fire [TERMS];
      decision_type    d;
      s = (sender > LOAD_FULL) ? LOAD_FULL : sender;
      r = (receiver > LOAD_FULL) ? LOAD_FULL : receiver;
      for (int i = 0; i < TERMS; i++) begin
         deg_s[i] = ramp_degree(s, LOAD_TERM[i], 256);
         deg_r[i] = ramp_degree(r, LOAD_TERM[i], 256);
         fire[i] = 0;
      end
      for (int i = 0; i < TERMS; i++)
         for (int j = 0; j < TERMS; j++) begin
            w = (deg_s[j] < deg_r[i]) ? deg_s[j] : deg_r[i];
            if (w > fire[DECISION_RULE[i][j]]) fire[DECISION_RULE[i][j]] = w;
         end
      sum_y = 0;
      sum_yx = 0;
      for (int k = 0; k < SAMPLES; k++) begin
         y = 0;
         for (int i = 0; i < TERMS; i++) begin
            m = ramp_degree((2 * k + 1) * 20, PROB_TERM[i], 2 * SAMPLES);
            if (m > fire[i]) m = fire[i];
            if (m > y) y = m;
         end
         sum_y += y;
         sum_yx += y * (2 * k + 1);
      end
      p = 0;
      if (sum_y != 0) begin
         den = 2 * SAMPLES * sum_y;
         p = (sum_yx * 32768 + den / 2) / den;
         if (p > 16'hFFFF) p = 16'hFFFF;
      end
      amount = 0;
      d.status = STATUS_ESCALATE;
      if (p > threshold_copy) begin
         d.status = STATUS_NO_MOVE;
         if (s > r) begin
            amount = (p * (s - r)) >> 16;
            if (amount > 16'h3FFF) amount = 16'h3FFF;
            if (amount > 0) d.status = STATUS_TRANSFER;
         end
      end
      d.probability = p[PROB_W-1:0];
      d.amount = amount[AMOUNT_W-1:0];
      return d;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_decisions.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            decision_type want;
            want = pending_decisions.pop_front();
            if (rsp_probability !== want.probability)
               report_mismatch("probability", rsp_probability, want.probability);
            if (rsp_transfer_amount !== want.amount)
               report_mismatch("transfer_amount", rsp_transfer_amount, want.amount);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_loads(input logic [LOAD_W-1:0] sender,
                             input logic [LOAD_W-1:0] receiver);
      req_sender_load = sender;
      req_receiver_load = receiver;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pending_decisions = {pending_decisions, predict_decision(sender, receiver)};
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_pipeline;
      start = 1'b0;
      while (pending_decisions.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [PROB_W-1:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = ADDR_THRESHOLD;
      pwdata = 32'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      threshold_copy = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
   endtask

   task automatic read_threshold;
      psel = 1'b1;
      pwrite = 1'b0;
      paddr = ADDR_THRESHOLD;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[PROB_W-1:0] !== threshold_copy)
         report_mismatch("threshold readback", prdata[PROB_W-1:0], threshold_copy);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      @(negedge clock);
   endtask

   // Term corners, clamping, equal loads, a difference too small to move and
   // a receiver heavier than the sender.
   task automatic test_directed;
      int corners [] = '{0, 10, 15, 25, 40, 50, 70, 90, 100};
      foreach (corners[i]) send_loads(LOAD_W'(corners[i] << 8), '0);
      send_loads(LOAD_W'(LOAD_FULL), LOAD_W'(LOAD_FULL));
      send_loads(15'h7FFF, '0);
      send_loads(15'h7FFF, 15'h7FFF);
      send_loads(LOAD_W'(LOAD_FULL + 1), 15'h4000);
      send_loads('0, LOAD_W'(LOAD_FULL));
      send_loads(LOAD_W'(20 << 8), LOAD_W'(20 << 8));
      send_loads(LOAD_W'((15 << 8) + 1), LOAD_W'(15 << 8));
      send_loads(LOAD_W'(3), LOAD_W'(2));
      send_loads(LOAD_W'(12 << 8), LOAD_W'(85 << 8));
      send_loads(LOAD_W'(95 << 8), LOAD_W'(5 << 8));
      send_loads(15'h2AAA, 15'h1555);
      send_loads(15'h1555, 15'h2AAA);
      drain_pipeline();
   endtask

   function automatic logic [LOAD_W-1:0] pick_load;
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return LOAD_W'($urandom_range(LOAD_FULL));
      if (sel < 85) return LOAD_W'($urandom_range(15'h7FFF));
      return LOAD_W'((LOAD_TERM[$urandom_range(TERMS - 1)][$urandom_range(3)] << 8)
                     + $urandom_range(4) - 2);
   endfunction

   task automatic test_random_phase(input logic [PROB_W-1:0] threshold,
                                    input int idle_pct, input int count);
      logic [LOAD_W-1:0] s, r;
      write_threshold(threshold);
      read_threshold();
      repeat (count) begin
         if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 4));
         s = pick_load();
         if ($urandom_range(9) == 0) r = (s > 3) ? s - LOAD_W'($urandom_range(3)) : s;
         else r = pick_load();
         send_loads(s, r);
      end
      drain_pipeline();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      read_threshold();
      test_directed();
      test_random_phase(16'd0, 0, 480);
      test_random_phase(16'd32768, 54, 480);
      test_random_phase(16'($urandom_range(32768)), 14, 480);
      test_random_phase(THRESHOLD_RESET, 54, 480);
      if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/fltd_pkg.sv
design/fuzzy_load_transfer_decision.sv
bench/fuzzy_load_transfer_decision_tb.sv
